// ===== rtl/v4alu_pkg.sv =====
package v4alu_pkg;

  localparam logic [3:0] FN_ADD   = 4'd0;
  localparam logic [3:0] FN_SUB   = 4'd1;
  localparam logic [3:0] FN_SCALE = 4'd2;
  localparam logic [3:0] FN_DIV   = 4'd3;
  localparam logic [3:0] FN_MAG   = 4'd4;
  localparam logic [3:0] FN_NORM  = 4'd5;
  localparam logic [3:0] FN_DOT   = 4'd6;
  localparam logic [3:0] FN_CROSS = 4'd7;
  localparam logic [3:0] FN_EQ    = 4'd8;
  localparam logic [3:0] FN_POINT = 4'd9;
  localparam logic [3:0] FN_VEC   = 4'd10;

  localparam logic [0:0] REG_TOL = 1'b0;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic signed [31:0] res_scalar;
    logic               res_flag;
    logic               div_zero;
  } out_t;

  // everything an item carries down the pipe besides the datapath words
  typedef struct packed {
    logic [3:0]       func;
    logic [3:0][31:0] vec;
    logic [31:0]      scalar;
    logic             flag;
    logic             dz;
    logic [3:0][31:0] num_mag;
    logic [3:0]       num_neg;
    logic [31:0]      den_mag;
    logic             den_neg;
    logic             den_zero;
  } pass_t;

endpackage

// ===== rtl/vec4_alu.sv =====
// pipeline depth is set by 32 square-root steps and 32 + FRAC_BITS divider steps
// throughput: one transaction per cycle; a stalled output freezes the whole pipe
// reset: asynchronous active low, clears all valid bits and sets the tolerance tol_q to 1
module vec4_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  v4alu_pkg::in_t    data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output v4alu_pkg::out_t   data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NW   = 32 + FRAC_BITS;
  localparam int SQ_N = 32;
  localparam int SQ0  = 2;
  localparam int DV0  = SQ0 + SQ_N + 1;
  localparam int LAST = DV0 + NW + 1;

  // ---------------- configuration ----------------
  logic [15:0] tol_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == v4alu_pkg::REG_TOL) ? {16'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr[2] == v4alu_pkg::REG_TOL) begin
      tol_q <= pwdata[15:0];
    end
  end

  // ---------------- helpers ----------------
  function automatic logic [31:0] sat68(logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'(v4alu_pkg::MAX32)) r = v4alu_pkg::MAX32;
    else if (v < 68'(v4alu_pkg::MIN32)) r = v4alu_pkg::MIN32;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [67:0] rnd68(logic signed [67:0] v);
    logic signed [67:0] h;
    h = 68'sd1 <<< (FRAC_BITS - 1);
    return (v + h) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] abs33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // ---------------- handshake ----------------
  logic            en;
  logic [LAST:0]   vld_q;

  assign en      = !(vld_q[LAST] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], valid_i};
    end
  end

  // ---------------- stage 0: input register ----------------
  v4alu_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= data_i;
    end
  end

  // ---------------- stage 1: multiplies, add/sub, tests ----------------
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic signed [63:0] prod_q [6];
  v4alu_pkg::pass_t   p1_d;
  v4alu_pkg::pass_t   p1_q;

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [32:0] diff [4];
  logic               eq_all;
  logic [32:0]        pt_abs;
  logic [32:0]        vc_abs;

  assign av[0] = in_q.a_x;
  assign av[1] = in_q.a_y;
  assign av[2] = in_q.a_z;
  assign av[3] = in_q.a_w;
  assign bv[0] = in_q.b_x;
  assign bv[1] = in_q.b_y;
  assign bv[2] = in_q.b_z;
  assign bv[3] = in_q.b_w;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = av[i % 4];
      mb[i] = av[i % 4];
    end
    if (in_q.func == v4alu_pkg::FN_SCALE) begin
      for (int i = 0; i < 4; i++) begin
        ma[i] = in_q.scale;
      end
    end else if (in_q.func == v4alu_pkg::FN_DOT) begin
      for (int i = 0; i < 4; i++) begin
        mb[i] = bv[i];
      end
    end else if (in_q.func == v4alu_pkg::FN_CROSS) begin
      ma[0] = in_q.a_y; mb[0] = in_q.b_z;
      ma[1] = in_q.a_z; mb[1] = in_q.b_y;
      ma[2] = in_q.a_z; mb[2] = in_q.b_x;
      ma[3] = in_q.a_x; mb[3] = in_q.b_z;
      ma[4] = in_q.a_x; mb[4] = in_q.b_y;
      ma[5] = in_q.a_y; mb[5] = in_q.b_x;
    end
  end

  always_comb begin
    eq_all = 1'b1;
    for (int i = 0; i < 4; i++) begin
      diff[i] = 33'(av[i]) - 33'(bv[i]);
      if (abs33(diff[i]) > {17'd0, tol_q}) eq_all = 1'b0;
    end
    pt_abs = abs33(33'(in_q.a_w) - (33'sd1 <<< FRAC_BITS));
    vc_abs = abs33(33'(in_q.a_w));

    p1_d = '0;
    p1_d.func = in_q.func;
    for (int i = 0; i < 4; i++) begin
      p1_d.num_mag[i] = abs32(av[i]);
      p1_d.num_neg[i] = av[i][31];
      if (in_q.func == v4alu_pkg::FN_ADD) begin
        p1_d.vec[i] = sat68(68'(av[i]) + 68'(bv[i]));
      end else if (in_q.func == v4alu_pkg::FN_SUB) begin
        p1_d.vec[i] = sat68(68'(av[i]) - 68'(bv[i]));
      end
    end
    p1_d.den_mag  = abs32(in_q.scale);
    p1_d.den_neg  = in_q.scale[31];
    p1_d.den_zero = (in_q.scale == 32'sd0);
    if (in_q.func == v4alu_pkg::FN_EQ) p1_d.flag = eq_all;
    else if (in_q.func == v4alu_pkg::FN_POINT) p1_d.flag = (pt_abs <= {17'd0, tol_q});
    else if (in_q.func == v4alu_pkg::FN_VEC) p1_d.flag = (vc_abs <= {17'd0, tol_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= ma[i] * mb[i];
      end
      p1_q <= p1_d;
    end
  end

  // ---------------- stage 2: sums and rounding ----------------
  v4alu_pkg::pass_t   p2_d;
  logic signed [67:0] pe [6];
  logic [67:0]        sumsq;

  v4alu_pkg::pass_t   sq_pass_q [SQ_N+1];
  logic [63:0]        sq_s_q    [SQ_N+1];
  logic [63:0]        sq_r_q    [SQ_N+1];
  logic               sq_cy_q   [SQ_N+1];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pe[i] = 68'(prod_q[i]);
    end
    sumsq = 68'(pe[0] + pe[1] + pe[2] + pe[3]);
    p2_d = p1_q;
    if (p1_q.func == v4alu_pkg::FN_SCALE) begin
      for (int i = 0; i < 4; i++) begin
        p2_d.vec[i] = sat68(rnd68(pe[i]));
      end
    end else if (p1_q.func == v4alu_pkg::FN_DOT) begin
      p2_d.scalar = sat68(rnd68(pe[0] + pe[1] + pe[2] + pe[3]));
    end else if (p1_q.func == v4alu_pkg::FN_CROSS) begin
      p2_d.vec[0] = sat68(rnd68(pe[0] - pe[1]));
      p2_d.vec[1] = sat68(rnd68(pe[2] - pe[3]));
      p2_d.vec[2] = sat68(rnd68(pe[4] - pe[5]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_pass_q[0] <= p2_d;
      sq_s_q[0]    <= sumsq[63:0];
      sq_r_q[0]    <= '0;
      sq_cy_q[0]   <= |sumsq[67:64];
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  for (genvar k = 1; k <= SQ_N; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
    logic [64:0] trial;

    assign trial = {1'b0, sq_r_q[k-1]} + {1'b0, BIT};

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_pass_q[k] <= sq_pass_q[k-1];
        sq_cy_q[k]   <= sq_cy_q[k-1];
        if ({1'b0, sq_s_q[k-1]} >= trial) begin
          sq_s_q[k] <= sq_s_q[k-1] - trial[63:0];
          sq_r_q[k] <= (sq_r_q[k-1] >> 1) + BIT;
        end else begin
          sq_s_q[k] <= sq_s_q[k-1];
          sq_r_q[k] <= sq_r_q[k-1] >> 1;
        end
      end
    end
  end

  // ---------------- divisor setup ----------------
  v4alu_pkg::pass_t dv_pass_q [NW+1];
  logic [32:0]      dv_den_q  [NW+1];
  logic [3:0][33:0] dv_rem_q  [NW+1];
  logic [3:0][NW-1:0] dv_sh_q [NW+1];

  v4alu_pkg::pass_t dv0_pass;
  logic [32:0]      dv0_den;
  logic [32:0]      mag;

  always_comb begin
    mag = sq_cy_q[SQ_N] ? 33'h1_0000_0000 : sq_r_q[SQ_N][32:0];
    dv0_pass = sq_pass_q[SQ_N];
    dv0_den  = 33'd1;
    if (dv0_pass.func == v4alu_pkg::FN_MAG || dv0_pass.func == v4alu_pkg::FN_NORM) begin
      dv0_pass.scalar = (mag > 33'h0_7fff_ffff) ? v4alu_pkg::MAX32 : mag[31:0];
    end
    if (dv0_pass.func == v4alu_pkg::FN_NORM) begin
      dv0_pass.dz = (mag == 33'd0);
      if (mag != 33'd0) dv0_den = mag;
    end else if (dv0_pass.func == v4alu_pkg::FN_DIV) begin
      dv0_pass.dz      = dv0_pass.den_zero;
      dv0_pass.num_neg = dv0_pass.num_neg ^ {4{dv0_pass.den_neg}};
      if (!dv0_pass.den_zero) dv0_den = {1'b0, dv0_pass.den_mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_pass_q[0] <= dv0_pass;
      dv_den_q[0]  <= dv0_den;
      for (int l = 0; l < 4; l++) begin
        dv_rem_q[0][l] <= '0;
        dv_sh_q[0][l]  <= {dv0_pass.num_mag[l], FRAC_BITS'(0)};
      end
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar j = 1; j <= NW; j++) begin : g_dv
    logic [3:0][33:0] r2;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        r2[l] = {dv_rem_q[j-1][l][32:0], dv_sh_q[j-1][l][NW-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_pass_q[j] <= dv_pass_q[j-1];
        dv_den_q[j]  <= dv_den_q[j-1];
        for (int l = 0; l < 4; l++) begin
          if (r2[l] >= {1'b0, dv_den_q[j-1]}) begin
            dv_rem_q[j][l] <= r2[l] - {1'b0, dv_den_q[j-1]};
            dv_sh_q[j][l]  <= {dv_sh_q[j-1][l][NW-2:0], 1'b1};
          end else begin
            dv_rem_q[j][l] <= r2[l];
            dv_sh_q[j][l]  <= {dv_sh_q[j-1][l][NW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- sign fixup and output register ----------------
  v4alu_pkg::pass_t pf;
  logic [3:0][31:0] vf;
  v4alu_pkg::out_t  out_d;
  v4alu_pkg::out_t  out_q;

  always_comb begin
    pf = dv_pass_q[NW];
    vf = pf.vec;
    if (pf.func == v4alu_pkg::FN_DIV || pf.func == v4alu_pkg::FN_NORM) begin
      for (int l = 0; l < 4; l++) begin
        if (pf.dz && pf.func == v4alu_pkg::FN_DIV) begin
          if (pf.num_mag[l] == 32'd0) vf[l] = '0;
          else vf[l] = pf.num_neg[l] ? v4alu_pkg::MIN32 : v4alu_pkg::MAX32;
        end else if (pf.num_neg[l]) begin
          if (dv_sh_q[NW][l] > NW'(33'h0_8000_0000)) vf[l] = v4alu_pkg::MIN32;
          else vf[l] = 32'(-dv_sh_q[NW][l]);
        end else begin
          if (dv_sh_q[NW][l] > NW'(33'h0_7fff_ffff)) vf[l] = v4alu_pkg::MAX32;
          else vf[l] = dv_sh_q[NW][l][31:0];
        end
      end
    end
    out_d.res_x      = vf[0];
    out_d.res_y      = vf[1];
    out_d.res_z      = vf[2];
    out_d.res_w      = vf[3];
    out_d.res_scalar = pf.scalar;
    out_d.res_flag   = pf.flag;
    out_d.div_zero   = pf.dz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule
